// File: hdl/ahfd_pkg.sv
package ahfd_pkg;

    // Widths of the fixed fields.
    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 11;
    localparam int COUNT_W     = 3;
    localparam int AFFIX_W     = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int NIBBLE_W    = 4;

    // Longest frame the position counter follows before it saturates.
    localparam int MAX_FRAME_CHARS = 1024;

    // Largest usable prefix or suffix count.
    localparam int MAX_AFFIX_CHARS = 4;
    localparam int AFFIX_LANES     = AFFIX_W / CHAR_W;
    localparam int AFFIX_LIMIT     =
        (MAX_AFFIX_CHARS < AFFIX_LANES) ? MAX_AFFIX_CHARS : AFFIX_LANES;

    // Character codes.
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_F  = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LO_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_DEL   = 8'h7F;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_DECODE_MODE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PREFIX_CHARS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PREFIX_COUNT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUFFIX_CHARS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUFFIX_COUNT = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [AFFIX_W-1:0] PREFIX_CHARS_RST = 32'h0000_003A;
    localparam logic [COUNT_W-1:0] PREFIX_COUNT_RST = 3'd1;
    localparam logic [AFFIX_W-1:0] SUFFIX_CHARS_RST = 32'h0000_0A0D;
    localparam logic [COUNT_W-1:0] SUFFIX_COUNT_RST = 3'd2;

    function automatic logic is_hex(input logic [CHAR_W-1:0] c);
        return ((c >= CHAR_0) && (c <= CHAR_9)) ||
               ((c >= CHAR_UP_A) && (c <= CHAR_UP_F)) ||
               ((c >= CHAR_LO_A) && (c <= CHAR_LO_F));
    endfunction

    function automatic logic [NIBBLE_W-1:0] nibble_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        if (c <= CHAR_9) begin
            v = c - CHAR_0;
        end else if (c <= CHAR_UP_F) begin
            v = c - CHAR_UP_A + 8'd10;
        end else begin
            v = c - CHAR_LO_A + 8'd10;
        end
        return v[NIBBLE_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] lim;
        lim = COUNT_W'(AFFIX_LIMIT);
        return (n > lim) ? lim : n;
    endfunction

    // True when c equals one of the first n characters of the packed set.
    function automatic logic in_set(input logic [CHAR_W-1:0]  c,
                                    input logic [AFFIX_W-1:0] chars,
                                    input logic [COUNT_W-1:0] n);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < AFFIX_LANES; i++) begin
            if ((COUNT_W'(i) < n) && (chars[i*CHAR_W +: CHAR_W] == c)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// File: hdl/ascii_hex_frame_decoder.sv
// Decoder for ASCII-coded frames. Each accepted character word gives exactly
// one result word in the next cycle, and a new character is accepted in every
// cycle while the result register is empty or being emptied; the single
// result register is what sets this rate of one character per cycle. In
// ASCII mode framing characters pass through at their prefix and suffix
// positions, two adjacent hex digits join into one byte (first digit high),
// and anything else gives a result with byte_valid low and byte_out zero. In
// hex mode every byte passes unchanged. frame_done copies frame_last, which
// also restarts the position count and drops any pending digit.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata; the user
// must write it only while the block is idle, which the block does not enforce.
module ascii_hex_frame_decoder #(
    parameter int MAX_FRAME_CHARS = ahfd_pkg::MAX_FRAME_CHARS
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic [ahfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ahfd_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ahfd_pkg::CHAR_W-1:0]       s_char_in,
    input  logic [ahfd_pkg::LEN_W-1:0]        s_frame_length,
    input  logic                              s_frame_last,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_byte_valid,
    output logic [ahfd_pkg::CHAR_W-1:0]       m_byte_out,
    output logic                              m_frame_done
);
    import ahfd_pkg::*;

    localparam int POS_W = (MAX_FRAME_CHARS > 2) ? $clog2(MAX_FRAME_CHARS) : 1;
    localparam int CMP_W = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_CHARS - 1);

    // Configuration registers.
    logic                decode_mode_reg;
    logic [AFFIX_W-1:0]  prefix_chars_reg;
    logic [COUNT_W-1:0]  prefix_count_reg;
    logic [AFFIX_W-1:0]  suffix_chars_reg;
    logic [COUNT_W-1:0]  suffix_count_reg;

    // Decoder state.
    logic [NIBBLE_W-1:0] held_digit_reg, held_digit_next;
    logic                held_valid_reg, held_valid_next;
    logic [POS_W-1:0]    pos_reg, pos_next;

    // Result register.
    logic                m_valid_reg;
    logic                byte_valid_reg, byte_valid_next;
    logic [CHAR_W-1:0]   byte_out_reg, byte_out_next;
    logic                frame_done_reg;

    logic                accept;
    logic                digit;
    logic [NIBBLE_W-1:0] digit_value;
    logic [COUNT_W-1:0]  pc;
    logic [COUNT_W-1:0]  sc;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    len_ext;
    logic [CMP_W-1:0]    sc_ext;
    logic                prefix_hit;
    logic                suffix_hit;
    logic                framing_ok;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign m_valid      = m_valid_reg;
    assign m_byte_valid = byte_valid_reg;
    assign m_byte_out   = byte_out_reg;
    assign m_frame_done = frame_done_reg;

    always_comb begin
        digit       = is_hex(s_char_in);
        digit_value = nibble_of(s_char_in);
        pc          = clamp_count(prefix_count_reg);
        sc          = clamp_count(suffix_count_reg);
        pos_ext     = CMP_W'(pos_reg);
        len_ext     = CMP_W'(s_frame_length);
        sc_ext      = CMP_W'(sc);

        prefix_hit = in_set(s_char_in, prefix_chars_reg, pc) &&
                     (pos_ext < CMP_W'(pc));
        // The suffix window only exists when the frame is at least as long
        // as the suffix.
        suffix_hit = in_set(s_char_in, suffix_chars_reg, sc) &&
                     (len_ext >= sc_ext) && (pos_ext >= (len_ext - sc_ext));
        framing_ok = (s_char_in < CHAR_DEL) && (prefix_hit || suffix_hit);

        held_valid_next = 1'b0;
        held_digit_next = '0;
        byte_valid_next = 1'b0;
        byte_out_next   = '0;

        if (!decode_mode_reg) begin
            byte_valid_next = 1'b1;
            byte_out_next   = s_char_in;
        end else if (held_valid_reg && digit) begin
            byte_valid_next = 1'b1;
            byte_out_next   = {held_digit_reg, digit_value};
        end else if (framing_ok) begin
            byte_valid_next = 1'b1;
            byte_out_next   = s_char_in;
        end else if (digit && ((pos_ext + CMP_W'(1)) < len_ext) && !s_frame_last) begin
            held_valid_next = 1'b1;
            held_digit_next = digit_value;
        end

        if (s_frame_last) begin
            pos_next        = '0;
            held_valid_next = 1'b0;
            held_digit_next = '0;
        end else if (pos_reg < POS_MAX) begin
            pos_next = pos_reg + POS_W'(1);
        end else begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decode_mode_reg  <= 1'b0;
            prefix_chars_reg <= PREFIX_CHARS_RST;
            prefix_count_reg <= PREFIX_COUNT_RST;
            suffix_chars_reg <= SUFFIX_CHARS_RST;
            suffix_count_reg <= SUFFIX_COUNT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DECODE_MODE:  decode_mode_reg  <= cfg_wdata[0];
                CFG_PREFIX_CHARS: prefix_chars_reg <= cfg_wdata[AFFIX_W-1:0];
                CFG_PREFIX_COUNT: prefix_count_reg <= cfg_wdata[COUNT_W-1:0];
                CFG_SUFFIX_CHARS: suffix_chars_reg <= cfg_wdata[AFFIX_W-1:0];
                CFG_SUFFIX_COUNT: suffix_count_reg <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_digit_reg <= '0;
            held_valid_reg <= 1'b0;
            pos_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                held_digit_reg <= held_digit_next;
                held_valid_reg <= held_valid_next;
                pos_reg        <= pos_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            byte_valid_reg <= byte_valid_next;
            byte_out_reg   <= byte_out_next;
            frame_done_reg <= s_frame_last;
        end
    end

endmodule

// File: tb/ascii_hex_frame_decoder_tb.sv
module ascii_hex_frame_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ahfd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_CHARS   = 88;
    localparam int LONG_DIGITS   = 1025;

    localparam logic [CHAR_W-1:0] COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] LF    = 8'h0A;

    typedef struct packed {
        logic              byte_valid;
        logic [CHAR_W-1:0] byte_out;
        logic              frame_done;
    } decoded_word_t;

    class frame_byte_scoreboard;
        logic                decode_mode;
        logic [AFFIX_W-1:0]  prefix_chars;
        logic [COUNT_W-1:0]  prefix_count;
        logic [AFFIX_W-1:0]  suffix_chars;
        logic [COUNT_W-1:0]  suffix_count;
        logic [NIBBLE_W-1:0] held_nibble;
        logic                held_ok;
        int unsigned         position;
        decoded_word_t       pending_bytes[$];
        int unsigned         mismatches;
        int unsigned         chars_seen;
        int unsigned         words_checked;
        int unsigned         bytes_made;

        function new();
            decode_mode   = 1'b0;
            prefix_chars  = PREFIX_CHARS_RST;
            prefix_count  = PREFIX_COUNT_RST;
            suffix_chars  = SUFFIX_CHARS_RST;
            suffix_count  = SUFFIX_COUNT_RST;
            held_nibble   = '0;
            held_ok       = 1'b0;
            position      = 0;
            mismatches    = 0;
            chars_seen    = 0;
            words_checked = 0;
            bytes_made    = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DECODE_MODE:  decode_mode  = data[0];
                CFG_PREFIX_CHARS: prefix_chars = data;
                CFG_PREFIX_COUNT: prefix_count = data[COUNT_W-1:0];
                CFG_SUFFIX_CHARS: suffix_chars = data;
                CFG_SUFFIX_COUNT: suffix_count = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned lanes_used(logic [COUNT_W-1:0] n);
            return (n > AFFIX_LIMIT) ? AFFIX_LIMIT : n;
        endfunction

        function bit in_lanes(logic [CHAR_W-1:0] c, logic [AFFIX_W-1:0] chars,
                              logic [COUNT_W-1:0] n);
            for (int i = 0; i < lanes_used(n); i++) begin
                if (chars[i*CHAR_W +: CHAR_W] == c) begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function int digit_value(logic [CHAR_W-1:0] c);
            if (c >= CHAR_0 && c <= CHAR_9) begin
                return c - CHAR_0;
            end
            if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
                return c - CHAR_UP_A + 10;
            end
            if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
                return c - CHAR_LO_A + 10;
            end
            return -1;
        endfunction

        // Framing characters pass only at their own positions. The suffix window
        // does not exist when the frame is shorter than the suffix.
        function bit framing_ok(logic [CHAR_W-1:0] c, int unsigned pos, int unsigned len);
            int unsigned tail;
            tail = lanes_used(suffix_count);
            if (c >= CHAR_DEL) begin
                return 1'b0;
            end
            if (in_lanes(c, prefix_chars, prefix_count) && pos < lanes_used(prefix_count)) begin
                return 1'b1;
            end
            if (in_lanes(c, suffix_chars, suffix_count) && len >= tail && pos >= len - tail) begin
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_char(logic [CHAR_W-1:0] c, logic [LEN_W-1:0] len, logic last);
            decoded_word_t w;
            int            digit;
            int unsigned   pos;
            int unsigned   flen;
            pos          = position;
            flen         = len;
            digit        = digit_value(c);
            w.byte_valid = 1'b0;
            w.byte_out   = '0;
            w.frame_done = last;
            if (!decode_mode) begin
                held_ok      = 1'b0;
                w.byte_valid = 1'b1;
                w.byte_out   = c;
            end else if (held_ok && digit >= 0) begin
                // The second digit of a pair is joined without any framing check.
                w.byte_valid = 1'b1;
                w.byte_out   = {held_nibble, digit[NIBBLE_W-1:0]};
                held_ok      = 1'b0;
            end else begin
                held_ok = 1'b0;
                if (framing_ok(c, pos, flen)) begin
                    w.byte_valid = 1'b1;
                    w.byte_out   = c;
                end else if (digit >= 0 && pos + 1 < flen && !last) begin
                    held_nibble = digit[NIBBLE_W-1:0];
                    held_ok     = 1'b1;
                end
            end
            if (last) begin
                position = 0;
                held_ok  = 1'b0;
            end else if (pos < MAX_FRAME_CHARS - 1) begin
                position = pos + 1;
            end
            chars_seen++;
            if (w.byte_valid) begin
                bytes_made++;
            end
            pending_bytes = {pending_bytes, w};
        endfunction

        function void check_byte(logic v, logic [CHAR_W-1:0] b, logic d);
            decoded_word_t want;
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected result word: byte_valid %0b byte_out %h frame_done %0b",
                         $time, v, b, d);
                mismatches++;
                return;
            end
            want = pending_bytes.pop_front();
            words_checked++;
            if (v !== want.byte_valid) begin
                $display("%0t: byte_valid expected %0b, got %0b", $time, want.byte_valid, v);
                mismatches++;
            end
            if (b !== want.byte_out) begin
                $display("%0t: byte_out expected %h, got %h", $time, want.byte_out, b);
                mismatches++;
            end
            if (d !== want.frame_done) begin
                $display("%0t: frame_done expected %0b, got %0b", $time, want.frame_done, d);
                mismatches++;
            end
        endfunction
    endclass

    logic                   aclk           = 1'b0;
    logic                   aresetn        = 1'b0;
    logic                   cfg_wr_en      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index      = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata      = '0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic [CHAR_W-1:0]      s_char_in      = '0;
    logic [LEN_W-1:0]       s_frame_length = '0;
    logic                   s_frame_last   = 1'b0;
    logic                   m_valid;
    logic                   m_ready        = 1'b1;
    logic                   m_byte_valid;
    logic [CHAR_W-1:0]      m_byte_out;
    logic                   m_frame_done;

    frame_byte_scoreboard sb = new();
    bit                   calm = 1'b0;
    int unsigned          cycle_count = 0;
    int unsigned          frames_sent = 0;
    int unsigned          settings_applied = 0;

    ascii_hex_frame_decoder i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_in      (s_char_in),
        .s_frame_length (s_frame_length),
        .s_frame_last   (s_frame_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_byte_valid   (m_byte_valid),
        .m_byte_out     (m_byte_out),
        .m_frame_done   (m_frame_done)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ascii_hex_frame_decoder test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_byte(m_byte_valid, m_byte_out, m_frame_done);
        end
    end

    // Result side: random stalls on m_ready unless the run is calm.
    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    function automatic logic [CHAR_W-1:0] rand_digit();
        int unsigned k;
        k = $urandom_range(0, 21);
        if (k < 10) begin
            return CHAR_W'(CHAR_0 + k);
        end else if (k < 16) begin
            return CHAR_W'(CHAR_UP_A + (k - 10));
        end
        return CHAR_W'(CHAR_LO_A + (k - 16));
    endfunction

    function automatic logic [AFFIX_W-1:0] rand_affix();
        logic [AFFIX_W-1:0] chars;
        for (int i = 0; i < AFFIX_W / CHAR_W; i++) begin
            case ($urandom_range(0, 3))
                0: chars[i*CHAR_W +: CHAR_W] = rand_digit();
                1: chars[i*CHAR_W +: CHAR_W] = CHAR_W'($urandom_range(0, 255));
                2: chars[i*CHAR_W +: CHAR_W] = CHAR_W'($urandom_range(8'h20, 8'h7E));
                default: begin
                    case ($urandom_range(0, 2))
                        0: chars[i*CHAR_W +: CHAR_W] = COLON;
                        1: chars[i*CHAR_W +: CHAR_W] = CR;
                        default: chars[i*CHAR_W +: CHAR_W] = LF;
                    endcase
                end
            endcase
        end
        return chars;
    endfunction

    task automatic write_setting(input logic mode, input logic [AFFIX_W-1:0] pchars,
                                 input logic [COUNT_W-1:0] pcount,
                                 input logic [AFFIX_W-1:0] schars,
                                 input logic [COUNT_W-1:0] scount);
        logic [CFG_INDEX_W-1:0] idx[5];
        logic [CFG_DATA_W-1:0]  val[5];
        idx = '{CFG_DECODE_MODE, CFG_PREFIX_CHARS, CFG_PREFIX_COUNT,
                CFG_SUFFIX_CHARS, CFG_SUFFIX_COUNT};
        val = '{CFG_DATA_W'(mode), pchars, CFG_DATA_W'(pcount), schars, CFG_DATA_W'(scount)};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
            sb.set_reg(idx[i], val[i]);
        end
        cfg_wr_en <= 1'b0;
        settings_applied++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending_bytes.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic [LEN_W-1:0] len,
                             input logic last);
        if (!calm && $urandom_range(0, 199) == 0) begin
            wait_drained();
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_char_in      <= c;
        s_frame_length <= len;
        s_frame_last   <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_char(c, len, last);
    endtask

    task automatic send_frame(input logic [CHAR_W-1:0] chars[$], input logic [LEN_W-1:0] len,
                              input logic closed);
        for (int i = 0; i < chars.size(); i++) begin
            send_char(chars[i], len, closed && (i == chars.size() - 1));
        end
        frames_sent++;
    endtask

    // Mostly well-formed frames under the current framing set; the rest are
    // corrupted, mislabeled, left open, or plain noise.
    task automatic random_frame();
        logic [CHAR_W-1:0] body[$];
        int unsigned       kind;
        int unsigned       nd;
        logic [LEN_W-1:0]  len;
        logic              closed;
        kind = $urandom_range(0, 9);
        if (kind <= 7) begin
            for (int i = 0; i < sb.lanes_used(sb.prefix_count); i++) begin
                body = {body, sb.prefix_chars[i*CHAR_W +: CHAR_W]};
            end
            nd = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 60) : 2 * $urandom_range(0, 8);
            repeat (nd) body = {body, rand_digit()};
            for (int i = 0; i < sb.lanes_used(sb.suffix_count); i++) begin
                body = {body, sb.suffix_chars[i*CHAR_W +: CHAR_W]};
            end
            if (kind >= 5) begin
                foreach (body[i]) begin
                    if ($urandom_range(0, 9) == 0) begin
                        body[i] = CHAR_W'($urandom_range(0, 255));
                    end
                end
            end
        end else begin
            repeat ($urandom_range(1, 20)) begin
                body = {body, (($urandom_range(0, 2) == 0) ? rand_digit()
                                                           : CHAR_W'($urandom_range(0, 255)))};
            end
        end
        if (body.size() == 0) begin
            body = {body, rand_digit()};
        end
        len    = LEN_W'(body.size());
        closed = 1'b1;
        if (kind == 6 || kind == 9) begin
            len = LEN_W'($urandom_range(1, MAX_FRAME_CHARS));
        end
        if (kind == 7 || (kind == 9 && $urandom_range(0, 1) == 0)) begin
            closed = 1'b0;
        end
        send_frame(body, len, closed);
    endtask

    initial begin
        logic [CHAR_W-1:0] frame[$];
        int unsigned       start;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset setting is hex mode: bytes pass unchanged.
        frame = '{8'h00};
        send_frame(frame, 11'd1, 1'b1);
        frame = '{8'hFF, COLON};
        send_frame(frame, 11'd1024, 1'b1);
        wait_drained();

        write_setting(1'b1, PREFIX_CHARS_RST, PREFIX_COUNT_RST, SUFFIX_CHARS_RST,
                      SUFFIX_COUNT_RST);
        frame = '{COLON, "1", "a", "F", "G", "9", "0", CR, LF};
        send_frame(frame, 11'd9, 1'b1);
        frame = '{COLON, "B", "7"};
        send_frame(frame, 11'd3, 1'b1);
        // A digit with no room left for its partner is dropped.
        frame = '{COLON, "5"};
        send_frame(frame, 11'd2, 1'b1);
        // One-character frame: shorter than the suffix, so CR is not framing.
        frame = '{CR};
        send_frame(frame, 11'd1, 1'b1);
        frame = '{"c", COLON, "e"};
        send_frame(frame, 11'd3, 1'b1);
        // Leave a digit pending, then switch to hex mode, which discards it.
        frame = '{COLON, "3"};
        send_frame(frame, 11'd4, 1'b0);
        wait_drained();
        write_setting(1'b0, PREFIX_CHARS_RST, PREFIX_COUNT_RST, SUFFIX_CHARS_RST,
                      SUFFIX_COUNT_RST);
        frame = '{"4"};
        send_frame(frame, 11'd4, 1'b1);
        wait_drained();

        // Counts above four clamp; DEL never passes; hex digits in the prefix set win.
        write_setting(1'b1, 32'hFF7F_4130, 3'd7, 32'h4639_0A0D, 3'd0);
        frame = '{8'h7F, "A", "0", 8'hFF};
        send_frame(frame, 11'd4, 1'b1);
        wait_drained();

        // One frame longer than the position counter: it saturates in the suffix window.
        write_setting(1'b1, PREFIX_CHARS_RST, PREFIX_COUNT_RST, SUFFIX_CHARS_RST,
                      SUFFIX_COUNT_RST);
        frame = '{COLON};
        repeat (LONG_DIGITS) frame = {frame, rand_digit()};
        frame = {frame, CR, LF, CR, LF};
        send_frame(frame, 11'(MAX_FRAME_CHARS), 1'b1);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            calm = (p == RANDOM_PHASES - 1) || ($urandom_range(0, 4) == 0);
            case (p)
                0: write_setting(1'b1, PREFIX_CHARS_RST, PREFIX_COUNT_RST, SUFFIX_CHARS_RST,
                                 SUFFIX_COUNT_RST);
                1: write_setting(1'b1, 32'hFFFF_FFFF, 3'd7, 32'h0000_0000, 3'd0);
                2: write_setting(1'b1, rand_affix(), 3'd4, rand_affix(), 3'd4);
                3: write_setting(1'b0, $urandom, COUNT_W'($urandom_range(0, 7)), $urandom,
                                 COUNT_W'($urandom_range(0, 7)));
                4: write_setting(1'b1, 32'h0000_0000, 3'd0, 32'hFFFF_FFFF, 3'd7);
                default: write_setting($urandom_range(0, 4) != 0, rand_affix(),
                                       COUNT_W'($urandom_range(0, 7)), rand_affix(),
                                       COUNT_W'($urandom_range(0, 7)));
            endcase
            start = sb.chars_seen;
            while (sb.chars_seen - start < PHASE_CHARS) begin
                random_frame();
            end
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        $display("Covered %0d characters in %0d frames under %0d register settings.",
                 sb.chars_seen, frames_sent, settings_applied);
        $display("Checked %0d result words, %0d carrying a byte; %0d mismatches.",
                 sb.words_checked, sb.bytes_made, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_bytes.size() == 0) begin
            $display("ascii_hex_frame_decoder test passed");
        end else begin
            $display("ascii_hex_frame_decoder test failed");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/ahfd_pkg.sv
hdl/ascii_hex_frame_decoder.sv
tb/ascii_hex_frame_decoder_tb.sv
